// ----- rtl/core/sprite_quad_vertex_batcher_core_assert.svh -----
// Assertion macros shared by the sprite quad vertex batcher RTL.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef SPRITE_QUAD_VERTEX_BATCHER_CORE_ASSERT_SVH
`define SPRITE_QUAD_VERTEX_BATCHER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SQVB_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SQVB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/sqvb_pkg.sv -----
// Package for the sprite quad vertex batcher: sizes, state codes and the
// control structures shared between the sequencer and its datapath units.
package sqvb_pkg;

  localparam int TEXTURE_SLOTS  = 32;
  localparam int SLOT_AW        = $clog2(TEXTURE_SLOTS);
  localparam int FILL_W         = $clog2(TEXTURE_SLOTS + 1);
  localparam int TEX_SLOT_W     = 5;
  localparam int HANDLE_W       = 16;

  localparam int SINE_ROM_DEPTH = 1024;
  localparam int SINE_AW        = $clog2(SINE_ROM_DEPTH);
  localparam int SINE_QUARTER   = SINE_ROM_DEPTH / 4;
  localparam int SINE_STEP      = 65536 / SINE_ROM_DEPTH;

  localparam int ANGLE_W = 16;
  localparam int TRIG_W  = 18;   // signed Q1.16, range -1.0 .. +1.0
  localparam int VAL_W   = 35;   // signed Q.17 corner coordinate with growth room
  localparam int ACC_W   = VAL_W + TRIG_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TRIG,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_ALLOC,
    S_LOAD,
    S_ROT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cz;
    logic signed [TRIG_W-1:0] sz;
    logic signed [TRIG_W-1:0] cy;
    logic signed [TRIG_W-1:0] sy;
    logic signed [TRIG_W-1:0] cx;
    logic signed [TRIG_W-1:0] sx;
  } trig_t;

  typedef struct packed {
    logic       load;
    logic [1:0] corner;
    logic       mac;
    logic [1:0] sel;
    logic [1:0] ph;
  } rot_ctrl_t;

  localparam logic [1:0] ROT_Z = 2'd0;
  localparam logic [1:0] ROT_Y = 2'd1;
  localparam logic [1:0] ROT_X = 2'd2;

endpackage

// ----- rtl/core/sqvb_channels_if.sv -----
// Valid/ready channel interfaces for quad requests and emitted vertices.
// Depends on nothing; widths follow the request and vertex field lists.
interface sqvb_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] scale_x;
  logic signed [31:0] scale_y;
  logic        [15:0] angle_x;
  logic        [15:0] angle_y;
  logic        [15:0] angle_z;
  logic        [31:0] rgba;
  logic               textured;
  logic        [15:0] texture_handle;
  logic signed [31:0] entity_tag;

  modport source (output valid, pos_x, pos_y, pos_z, scale_x, scale_y, angle_x, angle_y,
                  angle_z, rgba, textured, texture_handle, entity_tag, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, scale_x, scale_y, angle_x, angle_y,
                angle_z, rgba, textured, texture_handle, entity_tag, output ready);
endinterface

interface sqvb_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vert_x;
  logic signed [31:0] vert_y;
  logic signed [31:0] vert_z;
  logic        [31:0] vert_rgba;
  logic               tex_u;
  logic               tex_v;
  logic        [4:0]  tex_slot;
  logic signed [31:0] vert_entity;
  logic               batch_break;
  logic               last_vertex;

  modport source (output valid, vert_x, vert_y, vert_z, vert_rgba, tex_u, tex_v, tex_slot,
                  vert_entity, batch_break, last_vertex, input ready);
  modport sink (input valid, vert_x, vert_y, vert_z, vert_rgba, tex_u, tex_v, tex_slot,
                vert_entity, batch_break, last_vertex, output ready);
endinterface

// ----- rtl/core/sqvb_sine.sv -----
// Sine/cosine lookup with a registered output, built on a quarter-wave table.
// Depends on sqvb_pkg for the table depth and result width.
module sqvb_sine (
  input  logic                              clk,
  input  logic [sqvb_pkg::ANGLE_W-1:0]      angle,
  input  logic                              is_cos,
  output logic signed [sqvb_pkg::TRIG_W-1:0] value_r
);

  typedef logic [16:0] sin_rom_t [0:sqvb_pkg::SINE_QUARTER];

  // Odd Taylor series up to x^11 in unsigned Q2.30, rounded to Q1.16.
  function automatic logic [16:0] sin_entry(input int j);
    logic        [63:0] x;
    logic        [63:0] x2;
    logic        [63:0] term;
    logic signed [63:0] sum;
    logic signed [63:0] res;
    x    = (64'(j * sqvb_pkg::SINE_STEP) * 64'd1686629713) >> 14;
    x2   = (x * x) >> 30;
    sum  = $signed(x);
    term = ((x * x2) >> 30) / 6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - $signed(term);
    res  = (sum > 0) ? ((sum + 64'sd8192) >>> 14) : 64'sd0;
    if (res > 64'sd65536) begin
      res = 64'sd65536;
    end
    return res[16:0];
  endfunction

  function automatic sin_rom_t build_rom();
    sin_rom_t rom;
    for (int j = 0; j <= sqvb_pkg::SINE_QUARTER; j++) begin
      rom[j] = sin_entry(j);
    end
    return rom;
  endfunction

  localparam sin_rom_t SIN_ROM = build_rom();

  logic [sqvb_pkg::ANGLE_W-1:0] phase;
  logic [sqvb_pkg::SINE_AW-1:0] idx;
  logic [1:0]                   quad;
  logic [sqvb_pkg::SINE_AW-3:0] off;
  logic [sqvb_pkg::SINE_AW-2:0] ent;
  logic [16:0]                  mag;

  always_comb begin
    phase = angle + (is_cos ? sqvb_pkg::ANGLE_W'(16384) : '0);
    idx   = phase[sqvb_pkg::ANGLE_W-1 -: sqvb_pkg::SINE_AW];
    quad  = idx[sqvb_pkg::SINE_AW-1 -: 2];
    off   = idx[sqvb_pkg::SINE_AW-3:0];
    // Odd quadrants run the quarter wave backwards.
    ent   = quad[0] ? (sqvb_pkg::SINE_AW-1)'(sqvb_pkg::SINE_QUARTER) - {1'b0, off}
                    : {1'b0, off};
    mag   = SIN_ROM[ent];
  end

  always_ff @(posedge clk) begin
    value_r <= quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

endmodule

// ----- rtl/core/sqvb_slot_mem.sv -----
// Texture slot table: one write port and one read port with registered data.
// Depends on sqvb_pkg for depth and handle width; contents undefined until written.
module sqvb_slot_mem (
  input  logic                          clk,
  input  logic                          we,
  input  logic [sqvb_pkg::SLOT_AW-1:0]  waddr,
  input  logic [sqvb_pkg::HANDLE_W-1:0] wdata,
  input  logic [sqvb_pkg::SLOT_AW-1:0]  raddr,
  output logic [sqvb_pkg::HANDLE_W-1:0] rdata_r
);

  logic [sqvb_pkg::HANDLE_W-1:0] mem [sqvb_pkg::TEXTURE_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ----- rtl/core/sqvb_rot.sv -----
// Corner transform datapath: one shared multiplier and accumulator that
// applies the z, y and x rotations in turn. Depends on sqvb_pkg.
module sqvb_rot (
  input  logic                              clk,
  input  sqvb_pkg::rot_ctrl_t               ctrl,
  input  logic signed [31:0]                scale_x,
  input  logic signed [31:0]                scale_y,
  input  sqvb_pkg::trig_t                   trig,
  output logic signed [sqvb_pkg::VAL_W-1:0] x_r,
  output logic signed [sqvb_pkg::VAL_W-1:0] y_r,
  output logic signed [sqvb_pkg::VAL_W-1:0] z_r
);

  localparam int PROD_W = sqvb_pkg::VAL_W + sqvb_pkg::TRIG_W;

  logic signed [sqvb_pkg::VAL_W-1:0]  t_r;
  logic signed [sqvb_pkg::ACC_W-1:0]  acc_r;
  logic signed [sqvb_pkg::VAL_W-1:0]  p, q, mul_a, rv, sx_e, sy_e;
  logic signed [sqvb_pkg::TRIG_W-1:0] c, s, mul_b;
  logic signed [PROD_W-1:0]           prod;
  logic signed [sqvb_pkg::ACC_W-1:0]  prod_x, sum, rsum;
  logic                               x_neg, y_neg;

  always_comb begin
    case (ctrl.sel)
      sqvb_pkg::ROT_Z: begin p = x_r; q = y_r; c = trig.cz; s = trig.sz; end
      sqvb_pkg::ROT_Y: begin p = z_r; q = x_r; c = trig.cy; s = trig.sy; end
      default:         begin p = y_r; q = z_r; c = trig.cx; s = trig.sx; end
    endcase
    // Phases: p*c, minus q*s, p*s, plus q*c.
    mul_a  = (ctrl.ph == 2'd0 || ctrl.ph == 2'd2) ? p : q;
    mul_b  = (ctrl.ph == 2'd0 || ctrl.ph == 2'd3) ? c : s;
    prod   = mul_a * mul_b;
    prod_x = sqvb_pkg::ACC_W'(prod);
    sum    = (ctrl.ph == 2'd1) ? acc_r - prod_x : acc_r + prod_x;
    rsum   = sum + sqvb_pkg::ACC_W'(32768);
    rv     = sqvb_pkg::VAL_W'(rsum >>> 16);
    sx_e   = sqvb_pkg::VAL_W'(scale_x);
    sy_e   = sqvb_pkg::VAL_W'(scale_y);
    x_neg  = (ctrl.corner == 2'd0) || (ctrl.corner == 2'd3);
    y_neg  = ~ctrl.corner[1];
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x_r <= x_neg ? -sx_e : sx_e;
      y_r <= y_neg ? -sy_e : sy_e;
      z_r <= '0;
    end else if (ctrl.mac) begin
      case (ctrl.ph)
        2'd0, 2'd2: acc_r <= prod_x;
        2'd1:       t_r   <= rv;
        default: begin
          case (ctrl.sel)
            sqvb_pkg::ROT_Z: begin x_r <= t_r; y_r <= rv; end
            sqvb_pkg::ROT_Y: begin z_r <= t_r; x_r <= rv; end
            default:         begin y_r <= t_r; z_r <= rv; end
          endcase
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/sprite_quad_vertex_batcher_core.sv -----
// Sprite quad vertex batcher top level: sequencer, slot allocation, output register.
// Each quad runs six sine lookups for the trig factors, then the slot search (skipped when
// untextured), then per vertex a corner load, 12 multiplies and an output load. The 12 multiply
// steps per vertex on the one shared multiplier set the rate, unless the output stalls.
// Synchronous active-low reset sets the slot fill to 1 and idles the sequencer; the slot
// table itself is not cleared.
`include "sprite_quad_vertex_batcher_core_assert.svh"

module sprite_quad_vertex_batcher_core (
  input  logic        clk,
  input  logic        rst_n,
  sqvb_in_if.sink     in_ch,
  sqvb_out_if.source  out_ch
);

  // Request fields captured at the input transfer.
  logic signed [31:0] pos_x_r, pos_y_r, pos_z_r, scale_x_r, scale_y_r, entity_r;
  logic        [15:0] ang_x_r, ang_y_r, ang_z_r, handle_r;
  logic        [31:0] rgba_r;
  logic               tex_r;

  sqvb_pkg::state_t state_r, state_nxt;
  logic [2:0]                    trig_cnt_r;
  logic [sqvb_pkg::FILL_W-1:0]   fill_r, srch_idx_r;
  logic [sqvb_pkg::SLOT_AW-1:0]  slot_r;
  logic                          brk_r;
  logic [1:0]                    vert_r;
  logic [3:0]                    step_r;
  sqvb_pkg::trig_t               trig_r;

  logic in_xfer, out_load, table_full;
  logic [sqvb_pkg::ANGLE_W-1:0]  sin_angle;
  logic signed [sqvb_pkg::TRIG_W-1:0] sin_val;
  logic [sqvb_pkg::HANDLE_W-1:0] rd_handle;
  logic                          mem_we;
  logic [sqvb_pkg::SLOT_AW-1:0]  mem_waddr;
  sqvb_pkg::rot_ctrl_t           rctl;
  logic signed [sqvb_pkg::VAL_W-1:0] vx, vy, vz, vx1, vy1, vz1;

  assign in_ch.ready = (state_r == sqvb_pkg::S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign table_full  = (fill_r >= sqvb_pkg::FILL_W'(sqvb_pkg::TEXTURE_SLOTS));

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sqvb_pkg::S_IDLE:     if (in_xfer) state_nxt = sqvb_pkg::S_TRIG;
      sqvb_pkg::S_TRIG: begin
        if (trig_cnt_r == 3'd6) begin
          state_nxt = tex_r ? sqvb_pkg::S_SRCH_RD : sqvb_pkg::S_LOAD;
        end
      end
      sqvb_pkg::S_SRCH_RD: begin
        state_nxt = (srch_idx_r >= fill_r) ? sqvb_pkg::S_ALLOC : sqvb_pkg::S_SRCH_CMP;
      end
      sqvb_pkg::S_SRCH_CMP: begin
        state_nxt = (rd_handle == handle_r) ? sqvb_pkg::S_LOAD : sqvb_pkg::S_SRCH_RD;
      end
      sqvb_pkg::S_ALLOC:    state_nxt = sqvb_pkg::S_LOAD;
      sqvb_pkg::S_LOAD:     state_nxt = sqvb_pkg::S_ROT;
      sqvb_pkg::S_ROT:      if (step_r == 4'd11) state_nxt = sqvb_pkg::S_EMIT;
      sqvb_pkg::S_EMIT: begin
        if (out_load) begin
          state_nxt = (vert_r == 2'd3) ? sqvb_pkg::S_IDLE : sqvb_pkg::S_LOAD;
        end
      end
      default:              state_nxt = sqvb_pkg::S_IDLE;
    endcase
  end

  // Output and strobe logic of the sequencer.
  always_comb begin
    out_load    = (state_r == sqvb_pkg::S_EMIT) && (!out_ch.valid || out_ch.ready);
    mem_we      = (state_r == sqvb_pkg::S_ALLOC);
    mem_waddr   = table_full ? sqvb_pkg::SLOT_AW'(1) : fill_r[sqvb_pkg::SLOT_AW-1:0];
    rctl.load   = (state_r == sqvb_pkg::S_LOAD);
    rctl.corner = vert_r;
    rctl.mac    = (state_r == sqvb_pkg::S_ROT);
    rctl.sel    = step_r[3:2];
    rctl.ph     = step_r[1:0];
    case (trig_cnt_r[2:1])
      2'd0:    sin_angle = ang_z_r;
      2'd1:    sin_angle = ang_y_r;
      default: sin_angle = ang_x_r;
    endcase
  end

  sqvb_sine u_sine (
    .clk     (clk),
    .angle   (sin_angle),
    .is_cos  (~trig_cnt_r[0]),
    .value_r (sin_val)
  );

  sqvb_slot_mem u_slots (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (handle_r),
    .raddr   (srch_idx_r[sqvb_pkg::SLOT_AW-1:0]),
    .rdata_r (rd_handle)
  );

  sqvb_rot u_rot (
    .clk     (clk),
    .ctrl    (rctl),
    .scale_x (scale_x_r),
    .scale_y (scale_y_r),
    .trig    (trig_r),
    .x_r     (vx),
    .y_r     (vy),
    .z_r     (vz)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sqvb_pkg::S_IDLE;
      fill_r  <= sqvb_pkg::FILL_W'(1);
      out_ch.valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (mem_we) begin
        // A full table restarts at slot 1 and the new handle takes it.
        fill_r <= table_full ? sqvb_pkg::FILL_W'(2) : fill_r + 1'b1;
      end
      if (out_load) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  // Counters and payload; these need no reset since each phase preloads them.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pos_x_r    <= in_ch.pos_x;
      pos_y_r    <= in_ch.pos_y;
      pos_z_r    <= in_ch.pos_z;
      scale_x_r  <= in_ch.scale_x;
      scale_y_r  <= in_ch.scale_y;
      ang_x_r    <= in_ch.angle_x;
      ang_y_r    <= in_ch.angle_y;
      ang_z_r    <= in_ch.angle_z;
      rgba_r     <= in_ch.rgba;
      tex_r      <= in_ch.textured;
      handle_r   <= in_ch.texture_handle;
      entity_r   <= in_ch.entity_tag;
      trig_cnt_r <= '0;
      srch_idx_r <= sqvb_pkg::FILL_W'(1);
      slot_r     <= '0;
      brk_r      <= 1'b0;
      vert_r     <= '0;
    end
    if (state_r == sqvb_pkg::S_TRIG) begin
      trig_cnt_r <= trig_cnt_r + 1'b1;
      // The sine unit answers in the cycle after its angle is presented.
      case (trig_cnt_r)
        3'd1:    trig_r.cz <= sin_val;
        3'd2:    trig_r.sz <= sin_val;
        3'd3:    trig_r.cy <= sin_val;
        3'd4:    trig_r.sy <= sin_val;
        3'd5:    trig_r.cx <= sin_val;
        3'd6:    trig_r.sx <= sin_val;
        default: ;
      endcase
    end
    if (state_r == sqvb_pkg::S_SRCH_CMP) begin
      if (rd_handle == handle_r) begin
        slot_r <= srch_idx_r[sqvb_pkg::SLOT_AW-1:0];
      end
      srch_idx_r <= srch_idx_r + 1'b1;
    end
    if (mem_we) begin
      slot_r <= mem_waddr;
      brk_r  <= table_full;
    end
    if (state_r == sqvb_pkg::S_LOAD) begin
      step_r <= '0;
    end else if (state_r == sqvb_pkg::S_ROT) begin
      step_r <= step_r + 1'b1;
    end
    if (out_load) begin
      vert_r <= vert_r + 1'b1;
    end
  end

  // Round Q.17 to Q.16 (half up) and translate; the sum wraps to 32 bits.
  assign vx1 = vx + sqvb_pkg::VAL_W'(1);
  assign vy1 = vy + sqvb_pkg::VAL_W'(1);
  assign vz1 = vz + sqvb_pkg::VAL_W'(1);

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.vert_x      <= vx1[32:1] + pos_x_r;
      out_ch.vert_y      <= vy1[32:1] + pos_y_r;
      out_ch.vert_z      <= vz1[32:1] + pos_z_r;
      out_ch.vert_rgba   <= rgba_r;
      out_ch.tex_u       <= (vert_r == 2'd1) || (vert_r == 2'd2);
      out_ch.tex_v       <= vert_r[1];
      out_ch.tex_slot    <= sqvb_pkg::TEX_SLOT_W'(slot_r);
      out_ch.vert_entity <= entity_r;
      out_ch.batch_break <= brk_r && (vert_r == 2'd0);
      out_ch.last_vertex <= (vert_r == 2'd3);
    end
  end

  // The last vertex of the previous quad may still wait while the next quad runs,
  // so the untextured check looks only at the first three vertices.
  `SQVB_ASSERT_NOW(a_fill_range, clk, rst_n, 1'b1,
    (fill_r >= sqvb_pkg::FILL_W'(1)) && (fill_r <= sqvb_pkg::FILL_W'(sqvb_pkg::TEXTURE_SLOTS)),
    "slot fill out of range")
  `SQVB_ASSERT_NOW(a_break_slot, clk, rst_n, out_ch.valid && out_ch.batch_break,
    (out_ch.tex_slot == sqvb_pkg::TEX_SLOT_W'(1)) && !out_ch.tex_u && !out_ch.tex_v,
    "batch break not on first vertex of slot 1")
  `SQVB_ASSERT_NOW(a_plain_slot, clk, rst_n,
    out_ch.valid && !out_ch.last_vertex && !tex_r && !in_ch.ready,
    out_ch.tex_slot == '0, "untextured quad with nonzero slot")
  `SQVB_ASSERT_NEXT(a_last_idle, clk, rst_n, out_load && (vert_r == 2'd3),
    in_ch.ready && out_ch.valid && out_ch.last_vertex, "quad did not end after fourth vertex")

endmodule
